FILE: src/binary_trie_longest_prefix_match_defines.svh
// ---------------------------------------------------------------------------
// assertion macros shared by the route table checker
// ---------------------------------------------------------------------------
`ifndef BINARY_TRIE_LONGEST_PREFIX_MATCH_DEFINES_SVH
`define BINARY_TRIE_LONGEST_PREFIX_MATCH_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define BTLPM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define BTLPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/btlpm_pkg.sv
// ---------------------------------------------------------------------------
// btlpm_pkg
// types, sizes and control structs of the binary trie route table
// ---------------------------------------------------------------------------
package btlpm_pkg;

    // sizes
    localparam int NODE_COUNT = 65536;
    localparam int ADDR_W     = 32;
    localparam int IDX_W      = $clog2(NODE_COUNT);
    localparam int FREE_W     = IDX_W + 1;
    localparam int PORT_W     = 15;
    localparam int PLEN_W     = 6;
    localparam int DEPTH_W    = 6;

    // node types
    localparam logic NODE_ROUTE  = 1'b1;
    localparam logic NODE_BRANCH = 1'b0;

    // request kinds
    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_ADD    = 1'b1;

    // derived constants
    localparam logic [FREE_W-1:0]  FREE_LIMIT = FREE_W'(NODE_COUNT);
    localparam logic [FREE_W-1:0]  FREE_RESET = FREE_W'(1);
    localparam logic [DEPTH_W-1:0] DEPTH_MAX  = DEPTH_W'(ADDR_W);
    localparam logic [PLEN_W-1:0]  PLEN_MAX   = PLEN_W'(ADDR_W);

    // request payload
    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] addr;
        logic [PLEN_W-1:0] prefix_len;
        logic [PORT_W-1:0] route_port;
    } t_in;

    // result payload
    typedef struct packed {
        logic [PORT_W-1:0] port;
        logic              found;
        logic              table_full;
    } t_out;

    // one trie node in the store
    typedef struct packed {
        logic              ntype;
        logic [PORT_W-1:0] port;
        logic [IDX_W-1:0]  kid1;
        logic [IDX_W-1:0]  kid0;
    } t_node;

    localparam int NODE_W = $bits(t_node);

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic record;
        logic set_full;
        logic latch;
        logic alloc;
        logic finish;
        logic emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic kind;
        logic child_zero;
        logic depth_lt_plen;
        logic depth_max;
        logic table_full;
        logic out_busy;
    } t_sts;

endpackage

FILE: src/btlpm_ram.sv
// ---------------------------------------------------------------------------
// btlpm_ram
// simple dual-port ram, one write and one registered read per cycle
// ---------------------------------------------------------------------------
module btlpm_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: src/btlpm_datapath.sv
// ---------------------------------------------------------------------------
// btlpm_datapath
// trie walk registers, node store, free counter and result register
// ---------------------------------------------------------------------------
module btlpm_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  btlpm_pkg::t_cmd   i_cmd,
    output btlpm_pkg::t_sts   o_sts,
    input  btlpm_pkg::t_in    i_in_data,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output btlpm_pkg::t_out   o_out_data
);

    // request registers
    logic                                r_kind;
    logic [btlpm_pkg::ADDR_W-1:0]        r_addr;
    logic [btlpm_pkg::PLEN_W-1:0]        r_plen;
    logic [btlpm_pkg::PORT_W-1:0]        r_rport;

    // walk state
    logic [btlpm_pkg::DEPTH_W-1:0]       r_depth;
    logic [btlpm_pkg::IDX_W-1:0]         r_node;
    btlpm_pkg::t_node                    r_data;
    btlpm_pkg::t_node                    r_root;
    logic [btlpm_pkg::FREE_W-1:0]        r_free;

    // result
    logic [btlpm_pkg::PORT_W-1:0]        r_port;
    logic                                r_found;
    logic                                r_full;
    logic                                r_out_valid;
    btlpm_pkg::t_out                     r_out;

    // store signals
    logic [btlpm_pkg::NODE_W-1:0]        w_rd_data;
    logic [btlpm_pkg::IDX_W-1:0]         w_rd_addr;
    logic                                w_wr_en;
    btlpm_pkg::t_node                    n_wr_node;
    btlpm_pkg::t_node                    w_cur;
    logic [btlpm_pkg::IDX_W-1:0]         w_child;
    logic                                w_at_root;
    logic [btlpm_pkg::PLEN_W-1:0]        w_plen_in;
    logic [btlpm_pkg::FREE_W-1:0]        w_need;
    logic [btlpm_pkg::FREE_W-1:0]        w_free_end;

    // current node: root lives in flops, others come from the store
    assign w_at_root = (r_node == '0);
    assign w_cur     = w_at_root ? r_root : btlpm_pkg::t_node'(w_rd_data);
    assign w_child   = r_addr[btlpm_pkg::ADDR_W-1] ? w_cur.kid1 : w_cur.kid0;

    // read the child when stepping, otherwise keep the current node on the port
    assign w_rd_addr = i_cmd.step ? w_child : r_node;

    // clamp prefix length to the address width
    assign w_plen_in = (i_in_data.prefix_len > btlpm_pkg::PLEN_MAX)
                     ? btlpm_pkg::PLEN_MAX : i_in_data.prefix_len;

    // free nodes needed to finish the add
    assign w_need     = btlpm_pkg::FREE_W'(r_plen - btlpm_pkg::PLEN_W'(r_depth));
    assign w_free_end = r_free + w_need;

    // node rewrite: link the next free node, or mark the route at the end
    always_comb begin
        n_wr_node = r_data;
        if (i_cmd.finish) begin
            n_wr_node.ntype = btlpm_pkg::NODE_ROUTE;
            n_wr_node.port  = r_rport;
        end else if (r_addr[btlpm_pkg::ADDR_W-1]) begin
            n_wr_node.kid1 = r_free[btlpm_pkg::IDX_W-1:0];
        end else begin
            n_wr_node.kid0 = r_free[btlpm_pkg::IDX_W-1:0];
        end
    end

    assign w_wr_en = (i_cmd.alloc || i_cmd.finish) && !w_at_root;

    btlpm_ram #(
        .WIDTH (btlpm_pkg::NODE_W),
        .DEPTH (btlpm_pkg::NODE_COUNT)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_node),
        .i_wr_data (n_wr_node),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // request capture and walk registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= i_in_data.kind;
            r_addr  <= i_in_data.addr;
            r_plen  <= w_plen_in;
            r_rport <= i_in_data.route_port;
            r_depth <= '0;
            r_node  <= '0;
            r_port  <= '0;
            r_found <= 1'b0;
            r_full  <= 1'b0;
        end else begin
            if (i_cmd.record && (w_cur.ntype == btlpm_pkg::NODE_ROUTE)) begin
                r_port  <= w_cur.port;
                r_found <= 1'b1;
            end
            if (i_cmd.step) begin
                r_node  <= w_child;
                r_depth <= r_depth + 1'b1;
                r_addr  <= {r_addr[btlpm_pkg::ADDR_W-2:0], 1'b0};
            end
            if (i_cmd.set_full) begin
                r_full <= 1'b1;
            end
            if (i_cmd.latch) begin
                r_data <= w_cur;
            end
            if (i_cmd.alloc) begin
                r_node  <= r_free[btlpm_pkg::IDX_W-1:0];
                r_data  <= '0;
                r_depth <= r_depth + 1'b1;
                r_addr  <= {r_addr[btlpm_pkg::ADDR_W-2:0], 1'b0};
            end
        end
    end

    // root node and free counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root <= '0;
            r_free <= btlpm_pkg::FREE_RESET;
        end else begin
            if ((i_cmd.alloc || i_cmd.finish) && w_at_root) begin
                r_root <= n_wr_node;
            end
            if (i_cmd.alloc) begin
                r_free <= r_free + 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.port       <= r_port;
            r_out.found      <= r_found;
            r_out.table_full <= r_full;
        end
    end

    // status
    assign o_sts.kind          = r_kind;
    assign o_sts.child_zero    = (w_child == '0);
    assign o_sts.depth_lt_plen = (btlpm_pkg::PLEN_W'(r_depth) < r_plen);
    assign o_sts.depth_max     = (r_depth == btlpm_pkg::DEPTH_MAX);
    assign o_sts.table_full    = (w_free_end > btlpm_pkg::FREE_LIMIT);
    assign o_sts.out_busy      = r_out_valid && !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: src/btlpm_ctrl.sv
// ---------------------------------------------------------------------------
// btlpm_ctrl
// sequencer for trie walk, capacity check, node allocation and result
// ---------------------------------------------------------------------------
module btlpm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  btlpm_pkg::t_sts i_sts,
    output btlpm_pkg::t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WALK  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_ALLOC = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_WALK;
                end
            end
            S_WALK: begin
                if (i_sts.kind == btlpm_pkg::KIND_ADD) begin
                    if (i_sts.depth_lt_plen && !i_sts.child_zero) begin
                        o_cmd.step = 1'b1;
                    end else begin
                        n_state = S_CHECK;
                    end
                end else begin
                    o_cmd.record = 1'b1;
                    if (i_sts.depth_max || i_sts.child_zero) begin
                        n_state = S_DONE;
                    end else begin
                        o_cmd.step = 1'b1;
                    end
                end
            end
            S_CHECK: begin
                if (i_sts.table_full) begin
                    o_cmd.set_full = 1'b1;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_ALLOC;
                end
            end
            S_ALLOC: begin
                if (i_sts.depth_lt_plen) begin
                    o_cmd.alloc = 1'b1;
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: src/binary_trie_longest_prefix_match.sv
// ---------------------------------------------------------------------------
// binary_trie_longest_prefix_match
// ipv4 longest prefix match route table on a one-bit-per-level binary trie
// ---------------------------------------------------------------------------
// usage
//   request channel (i_in_valid / o_in_ready / i_in_data): kind 0 looks up
//   addr, kind 1 adds the route addr/prefix_len with route_port.
//   result channel (o_out_valid / i_out_ready / o_out_data): one result per
//   request, in request order: port and found for a lookup, table_full for
//   an add that found too few free nodes (nothing is changed then).
//   one request is worked at a time; o_in_ready is high only while idle.
//   the walk reads one trie level per cycle from the node store. a lookup
//   steps down along the address bits until a child is missing; an add
//   follows the existing levels, checks the free count and then adds a
//   node per missing level. o_in_ready returns as the result is loaded
//   into the output register.
//   reset empties the table (root cleared, free counter at node 1) at once,
//   with no clearing pass. a stalled result sits in the output register; the
//   next request is taken meanwhile and waits only to hand over its result.
// ---------------------------------------------------------------------------
module binary_trie_longest_prefix_match (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  btlpm_pkg::t_in  i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output btlpm_pkg::t_out o_out_data
);

    btlpm_pkg::t_cmd w_cmd;
    btlpm_pkg::t_sts w_sts;

    // sequencer
    btlpm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // trie datapath and node store
    btlpm_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: src/btlpm_checker.sv
// ---------------------------------------------------------------------------
// btlpm_checker
// port-level checks of the route table, bound to the top level
// ---------------------------------------------------------------------------
`include "binary_trie_longest_prefix_match_defines.svh"

module btlpm_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            o_in_ready,
    input logic            o_out_valid,
    input logic            i_out_ready,
    input btlpm_pkg::t_out o_out_data
);

    // a stalled result stays offered
    `BTLPM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid, "result dropped while stalled")

    // one request at a time: ready drops right after a request is taken
    `BTLPM_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "request taken while busy")

    // a refused add never reports a match
    `BTLPM_ASSERT_NOW(a_full_no_match, i_clk, i_rst_n, o_out_valid && o_out_data.table_full, !o_out_data.found && (o_out_data.port == '0), "full flag with match")

    // no match means port zero
    `BTLPM_ASSERT_NOW(a_miss_port_zero, i_clk, i_rst_n, o_out_valid && !o_out_data.found, o_out_data.port == '0, "port set without match")

endmodule

bind binary_trie_longest_prefix_match btlpm_checker u_checker (.*);

FILE: tb/sv/binary_trie_longest_prefix_match_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// binary_trie_longest_prefix_match_test
// drives lookups and route adds into the trie route table and checks every
// result against a software trie kept alongside
// ---------------------------------------------------------------------------
module binary_trie_longest_prefix_match_test;

    // shadow route table and queue of results still owed by the block
    class route_table_scoreboard;
        bit [btlpm_pkg::IDX_W-1:0]  kid [0:btlpm_pkg::NODE_COUNT-1][0:1];
        bit [btlpm_pkg::PORT_W-1:0] nport [0:btlpm_pkg::NODE_COUNT-1];
        bit                         ntype [0:btlpm_pkg::NODE_COUNT-1];
        int unsigned                next_free;
        btlpm_pkg::t_out            owed_results [$];
        int                         errors;
        int                         n_lookup;
        int                         n_found;
        int                         n_add;
        int                         n_refused;
        int                         n_checked;

        function new();
            next_free = btlpm_pkg::FREE_RESET;
        endfunction

        function int unsigned free_nodes();
            return btlpm_pkg::NODE_COUNT - next_free;
        endfunction

        // deepest route passed on the walk by address bits
        function btlpm_pkg::t_out lookup_route(logic [btlpm_pkg::ADDR_W-1:0] addr);
            btlpm_pkg::t_out           res;
            int unsigned               n;
            bit [btlpm_pkg::IDX_W-1:0] c;
            res = '0;
            n = 0;
            for (int d = 0; d <= btlpm_pkg::ADDR_W; d++) begin
                if (ntype[n] == btlpm_pkg::NODE_ROUTE) begin
                    res.port  = nport[n];
                    res.found = 1'b1;
                end
                if (d == btlpm_pkg::ADDR_W) break;
                c = kid[n][addr[btlpm_pkg::ADDR_W-1-d]];
                if (c == 0) break;
                n = c;
            end
            return res;
        endfunction

        // install a route, refusing it when too few nodes remain
        function btlpm_pkg::t_out add_route(btlpm_pkg::t_in req);
            btlpm_pkg::t_out res;
            int unsigned     n;
            int unsigned     nn;
            int              d;
            int              plen;
            res = '0;
            plen = (req.prefix_len > btlpm_pkg::PLEN_MAX) ? btlpm_pkg::ADDR_W
                                                          : int'(req.prefix_len);
            n = 0;
            d = 0;
            while (d < plen && kid[n][req.addr[btlpm_pkg::ADDR_W-1-d]] != 0) begin
                n = kid[n][req.addr[btlpm_pkg::ADDR_W-1-d]];
                d++;
            end
            if (next_free + (plen - d) > btlpm_pkg::NODE_COUNT) begin
                res.table_full = 1'b1;
                n_refused++;
                return res;
            end
            while (d < plen) begin
                nn = next_free;
                next_free++;
                kid[nn][0] = '0;
                kid[nn][1] = '0;
                nport[nn]  = '0;
                ntype[nn]  = btlpm_pkg::NODE_BRANCH;
                kid[n][req.addr[btlpm_pkg::ADDR_W-1-d]] = btlpm_pkg::IDX_W'(nn);
                n = nn;
                d++;
            end
            ntype[n] = btlpm_pkg::NODE_ROUTE;
            nport[n] = req.route_port;
            return res;
        endfunction

        function void note_request(btlpm_pkg::t_in req);
            btlpm_pkg::t_out res;
            if (req.kind == btlpm_pkg::KIND_ADD) begin
                n_add++;
                res = add_route(req);
            end else begin
                n_lookup++;
                res = lookup_route(req.addr);
                if (res.found) n_found++;
            end
            owed_results.push_back(res);
        endfunction

        function void check_result(btlpm_pkg::t_out got);
            btlpm_pkg::t_out want;
            if (owed_results.size() == 0) begin
                $error("result with no request outstanding: port %0h found %0b full %0b",
                       got.port, got.found, got.table_full);
                errors++;
                return;
            end
            want = owed_results.pop_front();
            n_checked++;
            if (got.port !== want.port) begin
                $error("port mismatch: expected %0h, actual %0h", want.port, got.port);
                errors++;
            end
            if (got.found !== want.found) begin
                $error("found mismatch: expected %0b, actual %0b", want.found, got.found);
                errors++;
            end
            if (got.table_full !== want.table_full) begin
                $error("table_full mismatch: expected %0b, actual %0b",
                       want.table_full, got.table_full);
                errors++;
            end
        endfunction
    endclass

    logic            i_clk;
    logic            i_rst_n;
    logic            in_valid;
    logic            in_ready;
    btlpm_pkg::t_in  in_data;
    logic            out_valid;
    logic            out_ready;
    btlpm_pkg::t_out out_data;

    int              send_idle_pct;
    int              recv_idle_pct;
    btlpm_pkg::t_in  route_log [$];

    route_table_scoreboard sb;

    binary_trie_longest_prefix_match uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // watchdog
    initial begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result side: random back-pressure, check on each accepted result
    initial begin
        out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready) begin
            sb.check_result(out_data);
        end
    end

    // mask keeping the top plen bits of an address
    function automatic logic [btlpm_pkg::ADDR_W-1:0] prefix_mask(int plen);
        if (plen <= 0) return '0;
        if (plen >= btlpm_pkg::ADDR_W) return '1;
        return ~({btlpm_pkg::ADDR_W{1'b1}} >> plen);
    endfunction

    function automatic btlpm_pkg::t_in pick_route();
        return route_log[$urandom_range(route_log.size() - 1)];
    endfunction

    // lookup, mostly inside a known route, with noise in the unused fields
    function automatic btlpm_pkg::t_in random_lookup();
        btlpm_pkg::t_in               r;
        btlpm_pkg::t_in               base;
        logic [btlpm_pkg::ADDR_W-1:0] m;
        r.kind       = btlpm_pkg::KIND_LOOKUP;
        r.prefix_len = btlpm_pkg::PLEN_W'($urandom);
        r.route_port = btlpm_pkg::PORT_W'($urandom);
        r.addr       = $urandom;
        if (route_log.size() > 0 && $urandom_range(99) < 70) begin
            base = pick_route();
            m = prefix_mask(base.prefix_len);
            r.addr = (base.addr & m) | ($urandom & ~m);
        end
        return r;
    endfunction

    // request side: one request per call, random idle cycles in front
    task automatic send_request(input btlpm_pkg::t_in req);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid = 1'b0;
            @(negedge i_clk);
        end
        in_valid = 1'b1;
        in_data  = req;
        do @(posedge i_clk); while (!in_ready);
        sb.note_request(req);
        if (req.kind == btlpm_pkg::KIND_ADD) begin
            route_log.push_back(req);
            if (route_log.size() > 4096) route_log.delete($urandom_range(4095));
        end
        @(negedge i_clk);
        in_valid = 1'b0;
    endtask

    task automatic send_fields(input logic kind,
                               input logic [btlpm_pkg::ADDR_W-1:0] addr,
                               input logic [btlpm_pkg::PLEN_W-1:0] plen,
                               input logic [btlpm_pkg::PORT_W-1:0] rport);
        btlpm_pkg::t_in r;
        r.kind       = kind;
        r.addr       = addr;
        r.prefix_len = plen;
        r.route_port = rport;
        send_request(r);
    endtask

    // mixed traffic: lookups, nested prefixes, overwrites, fresh routes
    task automatic run_random(input int count);
        btlpm_pkg::t_in               r;
        btlpm_pkg::t_in               base;
        int                           roll;
        int                           plen;
        logic [btlpm_pkg::ADDR_W-1:0] m;
        repeat (count) begin
            roll = $urandom_range(99);
            if (roll < 55) begin
                r = random_lookup();
            end else begin
                r.kind       = btlpm_pkg::KIND_ADD;
                r.route_port = btlpm_pkg::PORT_W'($urandom);
                if (route_log.size() > 0 && roll < 90) begin
                    base = pick_route();
                    if (roll < 65) begin
                        // same prefix again, new port
                        r.addr       = base.addr;
                        r.prefix_len = base.prefix_len;
                    end else begin
                        // nested or sibling prefix near a known route
                        plen = (base.prefix_len > btlpm_pkg::PLEN_MAX) ? btlpm_pkg::ADDR_W
                                                                      : base.prefix_len;
                        plen = plen + $urandom_range(6) - 2;
                        if (plen < 0) plen = 0;
                        if (plen > btlpm_pkg::ADDR_W) plen = btlpm_pkg::ADDR_W;
                        m = prefix_mask(base.prefix_len);
                        r.addr       = (base.addr & m) | ($urandom & ~m);
                        r.prefix_len = btlpm_pkg::PLEN_W'(plen);
                    end
                end else begin
                    r.addr = $urandom;
                    r.prefix_len = ($urandom_range(99) < 10) ?
                                   btlpm_pkg::PLEN_W'($urandom_range(63, 33)) :
                                   btlpm_pkg::PLEN_W'($urandom_range(btlpm_pkg::ADDR_W));
                end
            end
            send_request(r);
        end
    endtask

    // stimulus
    initial begin
        sb = new();
        i_rst_n  = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        send_idle_pct = 28;
        recv_idle_pct = 88;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: empty table, default route, nesting, full depth, clamping
        send_fields(btlpm_pkg::KIND_LOOKUP, 32'h0000_0000, 6'd0,  15'h0000);
        send_fields(btlpm_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 6'd63, 15'h7FFF);
        send_fields(btlpm_pkg::KIND_ADD,    32'h0000_0000, 6'd0,  15'h7FFF);
        send_fields(btlpm_pkg::KIND_LOOKUP, 32'h1234_5678, 6'd0,  15'h0000);
        send_fields(btlpm_pkg::KIND_ADD,    32'hC0A8_0000, 6'd16, 15'h0001);
        send_fields(btlpm_pkg::KIND_ADD,    32'hC0A8_0100, 6'd24, 15'h0002);
        send_fields(btlpm_pkg::KIND_LOOKUP, 32'hC0A8_0105, 6'd63, 15'h7FFF);
        send_fields(btlpm_pkg::KIND_LOOKUP, 32'hC0A8_FF01, 6'd0,  15'h0000);
        send_fields(btlpm_pkg::KIND_LOOKUP, 32'h0A00_0001, 6'd0,  15'h0000);
        send_fields(btlpm_pkg::KIND_ADD,    32'hFFFF_FFFF, 6'd32, 15'h0003);
        send_fields(btlpm_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 6'd0,  15'h0000);
        send_fields(btlpm_pkg::KIND_LOOKUP, 32'hFFFF_FFFE, 6'd0,  15'h0000);
        send_fields(btlpm_pkg::KIND_ADD,    32'h0000_0000, 6'd32, 15'h0000);
        send_fields(btlpm_pkg::KIND_LOOKUP, 32'h0000_0000, 6'd0,  15'h0000);
        send_fields(btlpm_pkg::KIND_ADD,    32'hC0A8_0000, 6'd16, 15'h1234);
        send_fields(btlpm_pkg::KIND_LOOKUP, 32'hC0A8_FF01, 6'd0,  15'h0000);
        send_fields(btlpm_pkg::KIND_ADD,    32'hAAAA_AAAA, 6'd63, 15'h5555);
        send_fields(btlpm_pkg::KIND_LOOKUP, 32'hAAAA_AAAA, 6'd0,  15'h0000);
        send_fields(btlpm_pkg::KIND_ADD,    32'h5555_5555, 6'd33, 15'h2AAA);
        send_fields(btlpm_pkg::KIND_LOOKUP, 32'h5555_5554, 6'd0,  15'h0000);
        send_fields(btlpm_pkg::KIND_LOOKUP, 32'h5555_5555, 6'd0,  15'h0000);
        send_fields(btlpm_pkg::KIND_ADD,    32'h8000_0000, 6'd1,  15'h0005);
        send_fields(btlpm_pkg::KIND_LOOKUP, 32'h8000_0001, 6'd0,  15'h0000);

        // random traffic under three idle patterns
        run_random(390);
        send_idle_pct = 88;
        recv_idle_pct = 28;
        run_random(390);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(390);

        // drain
        while (sb.owed_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.owed_results.size() != 0) begin
            $error("%0d results never arrived", sb.owed_results.size());
            sb.errors++;
        end

        $display("covered %0d lookups (%0d matched) and %0d route adds (%0d refused)",
                 sb.n_lookup, sb.n_found, sb.n_add, sb.n_refused);
        $display("checked %0d results, %0d free nodes left", sb.n_checked, sb.free_nodes());
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
